// ----- design/lpr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the longest-prefix route lookup.
// Used by lpr_cell and longest_prefix_route_lookup_top; depends on nothing.
package lpr_pkg;

	// Width of a table index carried along the chain; covers up to 256 entries.
	localparam int IDX_W = 8;

	typedef enum logic [1:0] {
		VERDICT_NO_ROUTE = 2'd0,
		VERDICT_LOCAL    = 2'd1,
		VERDICT_EXPIRED  = 2'd2,
		VERDICT_FORWARD  = 2'd3
	} verdict_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_ROUTE = 1'b1
	} mode_t;

	// Table write broadcast to every cell.
	typedef struct packed {
		logic        en;
		logic [3:0]  index;
		logic [31:0] prefix;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [15:0] port;
	} wr_t;

	// Search token handed from cell to cell.
	typedef struct packed {
		logic             valid;
		logic [31:0]      dest;
		logic [7:0]       ttl;
		logic [31:0]      best_mask;
		logic             have_best;
		logic [IDX_W-1:0] best_idx;
		logic [31:0]      best_gw;
		logic [15:0]      best_port;
		logic             have_dflt;
		logic [IDX_W-1:0] dflt_idx;
		logic [31:0]      dflt_gw;
		logic [15:0]      dflt_port;
	} tok_t;

endpackage

// ----- design/longest_prefix_route_lookup_top.sv -----
`timescale 1ns / 1ps
// Top level of the longest-prefix route lookup: stream ports, token injection and result staging.
// Depends on lpr_pkg and lpr_cell.

// The routing table lives in a row of MAX_ROUTES cells, one entry each. A write beat
// (tuser 0) stores its entry in the addressed cell in the cycle it is accepted, so write
// beats go at one per cycle while no route search holds the input. A route beat (tuser 1)
// launches a search token that walks the row one cell per cycle: the injection register,
// each cell's token register, then the result register, and then the output register once
// that is free. No further beat is accepted until the result has moved to the output
// register, so a route beat holds the input for the whole search, and longer while a full
// output register is not drained. A finished result may wait there while the next beat is taken.
// route_count is written through cfg_we/cfg_wdata; the user must write it only while the block is idle (not enforced).
module longest_prefix_route_lookup_top #(
	parameter int MAX_ROUTES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [4:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// entry_index, entry_prefix, entry_mask, entry_gateway, entry_port, dest_addr,
	// ttl_in, then four zero bits
	input  logic [159:0] s_axis_tdata,
	// mode
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// route_index, next_hop, out_port, ttl_out, then four zero bits
	output logic [63:0]  m_axis_tdata,
	// verdict
	output logic [1:0]   m_axis_tuser
);

	localparam int IW = lpr_pkg::IDX_W;

	logic [4:0] route_count_q;
	logic       busy_q;
	logic       accept;
	logic       route_acc;

	lpr_pkg::wr_t  wr;
	lpr_pkg::tok_t inject_d;
	lpr_pkg::tok_t inject_q;
	logic          inject_valid_q;
	lpr_pkg::tok_t chain [MAX_ROUTES+1];
	lpr_pkg::tok_t tail;

	lpr_pkg::verdict_t verdict_d;
	logic [IW-1:0]     chosen;
	logic [IW+3:0]     chosen_ext;
	logic [31:0]       gw_sel;
	logic [15:0]       port_sel;
	logic [31:0]       hop_d;
	logic [15:0]       oport_d;
	logic [7:0]        ttl_d;

	logic              pend_valid_q;
	lpr_pkg::verdict_t pend_verdict_q;
	logic [3:0]        pend_idx_q;
	logic [31:0]       pend_hop_q;
	logic [15:0]       pend_port_q;
	logic [7:0]        pend_ttl_q;

	logic              out_valid_q;
	lpr_pkg::verdict_t out_verdict_q;
	logic [3:0]        out_idx_q;
	logic [31:0]       out_hop_q;
	logic [15:0]       out_port_q;
	logic [7:0]        out_ttl_q;
	logic              out_load;

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign route_acc     = accept && (s_axis_tuser == lpr_pkg::MODE_ROUTE);

	assign wr.en      = accept && (s_axis_tuser == lpr_pkg::MODE_WRITE);
	assign wr.index   = s_axis_tdata[3:0];
	assign wr.prefix  = s_axis_tdata[35:4];
	assign wr.mask    = s_axis_tdata[67:36];
	assign wr.gateway = s_axis_tdata[99:68];
	assign wr.port    = s_axis_tdata[115:100];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= 5'd0;
		end else if (cfg_we) begin
			route_count_q <= cfg_wdata;
		end
	end

	// Fresh token: nothing found yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inject_valid_q <= 1'b0;
		end else begin
			inject_valid_q <= route_acc;
		end
	end

	always_comb begin
		inject_d      = '0;
		inject_d.dest = s_axis_tdata[147:116];
		inject_d.ttl  = s_axis_tdata[155:148];
	end

	always_ff @(posedge clk) begin
		if (route_acc) begin
			inject_q <= inject_d;
		end
	end

	always_comb begin
		chain[0]       = inject_q;
		chain[0].valid = inject_valid_q;
	end

	for (genvar g = 0; g < MAX_ROUTES; g++) begin : g_cell
		lpr_cell #(
			.CELL_IDX (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.wr          (wr),
			.route_count (route_count_q),
			.tok_i       (chain[g]),
			.tok_o       (chain[g+1])
		);
	end

	assign tail = chain[MAX_ROUTES];

	always_comb begin
		chosen   = '0;
		gw_sel   = 32'd0;
		port_sel = 16'd0;
		if (tail.have_best) begin
			chosen   = tail.best_idx;
			gw_sel   = tail.best_gw;
			port_sel = tail.best_port;
		end else if (tail.have_dflt) begin
			chosen   = tail.dflt_idx;
			gw_sel   = tail.dflt_gw;
			port_sel = tail.dflt_port;
		end
		hop_d   = 32'd0;
		oport_d = 16'd0;
		ttl_d   = tail.ttl;
		if (!tail.have_best && !tail.have_dflt) begin
			verdict_d = lpr_pkg::VERDICT_NO_ROUTE;
		end else if (gw_sel == 32'd0) begin
			verdict_d = lpr_pkg::VERDICT_LOCAL;
		end else if (tail.ttl == 8'd0) begin
			verdict_d = lpr_pkg::VERDICT_EXPIRED;
		end else begin
			verdict_d = lpr_pkg::VERDICT_FORWARD;
			hop_d     = gw_sel;
			oport_d   = port_sel;
			ttl_d     = tail.ttl - 8'd1;
		end
	end

	assign chosen_ext = {4'b0, chosen};
	assign out_load   = pend_valid_q && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (route_acc) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
			if (tail.valid) begin
				pend_valid_q <= 1'b1;
			end else if (out_load) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			pend_verdict_q <= verdict_d;
			pend_idx_q     <= chosen_ext[3:0];
			pend_hop_q     <= hop_d;
			pend_port_q    <= oport_d;
			pend_ttl_q     <= ttl_d;
		end
		if (out_load) begin
			out_verdict_q <= pend_verdict_q;
			out_idx_q     <= pend_idx_q;
			out_hop_q     <= pend_hop_q;
			out_port_q    <= pend_port_q;
			out_ttl_q     <= pend_ttl_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_verdict_q;
	assign m_axis_tdata  = {4'b0, out_ttl_q, out_port_q, out_hop_q, out_idx_q};

endmodule

// ----- design/lpr_cell.sv -----
`timescale 1ns / 1ps
// One routing table entry with its stage of the search chain.
// Depends on lpr_pkg for the write and token types.
module lpr_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lpr_pkg::wr_t  wr,
	input  logic [4:0]    route_count,
	input  lpr_pkg::tok_t tok_i,
	output lpr_pkg::tok_t tok_o
);

	localparam logic [lpr_pkg::IDX_W-1:0] MY_IDX = CELL_IDX[lpr_pkg::IDX_W-1:0];

	logic [31:0] prefix_q;
	logic [31:0] mask_q;
	logic [31:0] gateway_q;
	logic [15:0] port_q;

	logic          valid_q;
	lpr_pkg::tok_t tok_q;
	lpr_pkg::tok_t tok_d;
	logic          active;
	logic          is_match;
	logic          is_dflt;

	always_ff @(posedge clk) begin
		if (wr.en && ({4'b0, wr.index} == MY_IDX)) begin
			prefix_q  <= wr.prefix;
			mask_q    <= wr.mask;
			gateway_q <= wr.gateway;
			port_q    <= wr.port;
		end
	end

	// The entry takes part only when it lies inside the configured count.
	assign active   = ({3'b0, route_count} > MY_IDX);
	assign is_match = active && (((prefix_q ^ tok_i.dest) & mask_q) == 32'd0)
		&& (mask_q > tok_i.best_mask);
	assign is_dflt  = active && (prefix_q == 32'd0) && (mask_q == 32'd0);

	always_comb begin
		tok_d = tok_i;
		if (is_match) begin
			tok_d.best_mask = mask_q;
			tok_d.have_best = 1'b1;
			tok_d.best_idx  = MY_IDX;
			tok_d.best_gw   = gateway_q;
			tok_d.best_port = port_q;
		end
		if (is_dflt) begin
			tok_d.have_dflt = 1'b1;
			tok_d.dflt_idx  = MY_IDX;
			tok_d.dflt_gw   = gateway_q;
			tok_d.dflt_port = port_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_o       = tok_q;
		tok_o.valid = valid_q;
	end

endmodule
